// File: rtl/glic_pkg.sv
// Package with the shared constants and types of the grow light and irrigation controller.
package glic_pkg;

  // Field widths.
  localparam int unsigned LevelW   = 12;
  localparam int unsigned TimeW    = 11;
  localparam int unsigned CountW   = 16;
  localparam int unsigned PercentW = 7;
  localparam int unsigned KindW    = 2;
  localparam int unsigned ModeW    = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Divider geometry: dividend is a 12 by 12 bit product.
  localparam int unsigned DivW     = 2 * LevelW;
  localparam int unsigned DivCntW  = $clog2(DivW);

  // Constants of the control law.
  localparam logic [LevelW-1:0]   FullDrive  = 12'd4095;
  localparam logic [LevelW-1:0]   RampStep   = 12'd20;
  localparam logic [PercentW-1:0] PercentMax = 7'd100;
  localparam logic [1:0]          DryNeeded  = 2'd2;
  localparam logic [1:0]          StreakMax  = 2'd3;
  localparam logic [CountW-1:0]   CountMax   = 16'hFFFF;

  // Mode flag bit positions.
  localparam int unsigned ModeLightAuto = 0;
  localparam int unsigned ModePumpAuto  = 1;
  localparam int unsigned ModeGreenOn   = 2;
  localparam int unsigned ModeInvert    = 3;

  // Item kinds.
  typedef enum logic [KindW-1:0] {
    KIND_TICK   = 2'd0,
    KIND_WATER  = 2'd1,
    KIND_FORCE  = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DRY_LEVEL    = 3'd0,
    CFG_FAULT_LEVEL  = 3'd1,
    CFG_LIGHT_LOW    = 3'd2,
    CFG_LIGHT_HIGH   = 3'd3,
    CFG_WINDOW_START = 3'd4,
    CFG_WINDOW_STOP  = 3'd5,
    CFG_HOLD_OFF     = 3'd6,
    CFG_MODE_FLAGS   = 3'd7
  } cfg_idx_e;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DROP = 5'b00010,
    S_PCT  = 5'b00100,
    S_RAMP = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

endpackage

// File: rtl/glic_intf.sv
// Handshake interfaces for the input, result and configuration channels.
interface glic_in_if
  import glic_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [KindW-1:0]  kind;
  logic              minute_tick;
  logic [TimeW-1:0]  time_of_day;
  logic [LevelW-1:0] ambient_level;
  logic [LevelW-1:0] soil_level;
  logic              tank_has_water;
  logic              force_value;

  modport source (output valid, kind, minute_tick, time_of_day, ambient_level,
                  soil_level, tank_has_water, force_value, input ready);
  modport sink   (input valid, kind, minute_tick, time_of_day, ambient_level,
                  soil_level, tank_has_water, force_value, output ready);
endinterface

interface glic_out_if
  import glic_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [LevelW-1:0]   red_drive;
  logic [LevelW-1:0]   green_drive;
  logic [LevelW-1:0]   blue_drive;
  logic [PercentW-1:0] light_percent;
  logic                pump_pulse;
  logic [CountW-1:0]   minutes_since_water;
  logic                light_allowed;

  modport source (output valid, red_drive, green_drive, blue_drive, light_percent,
                  pump_pulse, minutes_since_water, light_allowed, input ready);
  modport sink   (input valid, red_drive, green_drive, blue_drive, light_percent,
                  pump_pulse, minutes_since_water, light_allowed, output ready);
endinterface

interface glic_cfg_if
  import glic_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/grow_light_and_irrigation_controller_top.sv
// Top level of the grow light and irrigation controller with its sequencer and shared divider.
// Sequencing: a command, a plain second tick, or a minute tick whose target needs no division
//   passes through the ramp and output states to the result register; a minute tick that maps
//   the ambient level first runs the 24-step restoring division and then the percent state.
// Acceptance: one item at a time, input being ready only in the idle state; the 24-step shared
//   restoring divider and a stalled output hold off the next; the result register lets it in.
// Reset: asynchronous, active low; clears all control state and loads register defaults.
module grow_light_and_irrigation_controller_top
  import glic_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  glic_in_if.sink    in_i,
  glic_out_if.source out_o,
  glic_cfg_if.sink   cfg_i
);

  // Configuration registers.
  logic [LevelW-1:0] dry_level_q, fault_level_q, light_low_q, light_high_q;
  logic [TimeW-1:0]  window_start_q, window_stop_q;
  logic [CountW-1:0] hold_off_q;
  logic [ModeW-1:0]  mode_q;

  // Controller state.
  state_e              state_q, state_d;
  logic [LevelW-1:0]   ramp_q, target_q;
  logic [PercentW-1:0] percent_q;
  logic                allowed_q, forced_q, pulse_q, tick_q;
  logic [CountW-1:0]   count_q;
  logic [1:0]          streak_q;

  // Shared divider.
  logic [DivW-1:0]    quo_q;
  logic [LevelW-1:0]  rem_q, dsr_q;
  logic [DivCntW-1:0] cnt_q;

  // Result register.
  logic                out_valid_q;
  logic [LevelW-1:0]   red_q, green_q, blue_q;
  logic [PercentW-1:0] out_pct_q;
  logic                out_pulse_q, out_allowed_q;
  logic [CountW-1:0]   out_count_q;

  logic in_acc, out_free;
  assign in_i.ready  = (state_q == S_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;
  assign cfg_i.ready = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dry_level_q    <= '0;
      fault_level_q  <= FullDrive;
      light_low_q    <= '0;
      light_high_q   <= FullDrive;
      window_start_q <= '0;
      window_stop_q  <= '0;
      hold_off_q     <= '0;
      mode_q         <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_DRY_LEVEL:    dry_level_q    <= cfg_i.data[LevelW-1:0];
        CFG_FAULT_LEVEL:  fault_level_q  <= cfg_i.data[LevelW-1:0];
        CFG_LIGHT_LOW:    light_low_q    <= cfg_i.data[LevelW-1:0];
        CFG_LIGHT_HIGH:   light_high_q   <= cfg_i.data[LevelW-1:0];
        CFG_WINDOW_START: window_start_q <= cfg_i.data[TimeW-1:0];
        CFG_WINDOW_STOP:  window_stop_q  <= cfg_i.data[TimeW-1:0];
        CFG_HOLD_OFF:     hold_off_q     <= cfg_i.data[CountW-1:0];
        CFG_MODE_FLAGS:   mode_q         <= cfg_i.data[ModeW-1:0];
        default: ;
      endcase
    end
  end

  // Minute evaluation on the incoming item: window, counter, watering decision and light mapping.
  logic              win, allowed_n, forced_n, pump_ok, soil_dry, fire, light_on, map_div;
  logic [CountW-1:0] count_inc, count_n;
  logic [1:0]        streak_n;
  logic [LevelW-1:0] amb_ofs;
  logic [DivW-1:0]   drop_dvd;

  always_comb begin
    count_inc = (count_q == CountMax) ? count_q : count_q + 1'b1;
    win       = (window_start_q < in_i.time_of_day) && (in_i.time_of_day < window_stop_q);
    allowed_n = win ? 1'b1 : forced_q;
    forced_n  = win ? 1'b0 : forced_q;
    pump_ok   = mode_q[ModePumpAuto] && (hold_off_q < count_inc) && in_i.tank_has_water;
    soil_dry  = (in_i.soil_level > dry_level_q) && (in_i.soil_level < fault_level_q);
    streak_n  = streak_q;
    if (pump_ok) begin
      if (!soil_dry) begin
        streak_n = '0;
      end else if (streak_q < StreakMax) begin
        streak_n = streak_q + 1'b1;
      end
    end
    fire    = pump_ok && (streak_n >= DryNeeded) && allowed_n;
    count_n = count_inc;
    if (fire) begin
      count_n  = '0;
      streak_n = '0;
    end
    if (!mode_q[ModePumpAuto]) begin
      count_n = hold_off_q;
    end
    light_on = mode_q[ModeLightAuto] && allowed_n;
    map_div  = light_on && (in_i.ambient_level > light_low_q)
               && (in_i.ambient_level < light_high_q);
    // (a - low) * 4095 as a shift and subtract.
    amb_ofs  = in_i.ambient_level - light_low_q;
    drop_dvd = {amb_ofs, {LevelW{1'b0}}} - {{LevelW{1'b0}}, amb_ofs};
  end

  // One restoring divider step.
  logic [LevelW+1:0] trial;
  logic              borrow;
  logic [LevelW-1:0] rem_n;
  logic [DivW-1:0]   quo_n;
  logic              div_last;

  always_comb begin
    trial    = {1'b0, rem_q, quo_q[DivW-1]} - {2'b00, dsr_q};
    borrow   = trial[LevelW+1];
    rem_n    = borrow ? {rem_q[LevelW-2:0], quo_q[DivW-1]} : trial[LevelW-1:0];
    quo_n    = {quo_q[DivW-2:0], !borrow};
    div_last = (cnt_q == DivCntW'(DivW - 1));
  end

  // Percent of the new target, target * 100 / 4095. For a product below 2^19 the
  // quotient by 4095 is (p + (p >> 12) + 1) >> 12.
  logic [LevelW+PercentW-1:0] pct_prod, pct_sum;
  logic [PercentW-1:0]        pct_n;

  always_comb begin
    pct_prod = ({{PercentW{1'b0}}, target_q} << 6) + ({{PercentW{1'b0}}, target_q} << 5)
               + ({{PercentW{1'b0}}, target_q} << 2);
    pct_sum  = pct_prod + (pct_prod >> LevelW) + 1'b1;
    pct_n    = pct_sum[LevelW+PercentW-1:LevelW];
  end

  // Ramp toward the target by at most one step.
  logic [LevelW-1:0] ramp_n;

  always_comb begin
    ramp_n = ramp_q;
    if (ramp_q > target_q) begin
      ramp_n = ((ramp_q - target_q) > RampStep) ? ramp_q - RampStep : target_q;
    end else if (ramp_q < target_q) begin
      ramp_n = ((target_q - ramp_q) > RampStep) ? ramp_q + RampStep : target_q;
    end
  end

  // Sequencer transitions.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = (kind_e'(in_i.kind) == KIND_TICK && in_i.minute_tick && map_div)
                    ? S_DROP : S_RAMP;
        end
      end
      S_DROP:  if (div_last) state_d = S_PCT;
      S_PCT:   state_d = S_RAMP;
      S_RAMP:  state_d = S_OUT;
      S_OUT:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Controller state and divider registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ramp_q    <= '0;
      target_q  <= '0;
      percent_q <= '0;
      allowed_q <= 1'b0;
      forced_q  <= 1'b0;
      count_q   <= '0;
      streak_q  <= '0;
      pulse_q   <= 1'b0;
      tick_q    <= 1'b0;
      cnt_q     <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            pulse_q <= 1'b0;
            tick_q  <= (kind_e'(in_i.kind) == KIND_TICK);
            cnt_q   <= '0;
            case (kind_e'(in_i.kind))
              KIND_TICK: begin
                if (in_i.minute_tick) begin
                  allowed_q <= allowed_n;
                  forced_q  <= forced_n;
                  count_q   <= count_n;
                  streak_q  <= streak_n;
                  pulse_q   <= fire;
                  if (!map_div) begin
                    target_q  <= (light_on && in_i.ambient_level <= light_low_q)
                                 ? FullDrive : '0;
                    percent_q <= (light_on && in_i.ambient_level <= light_low_q)
                                 ? PercentMax : '0;
                  end
                end
              end
              KIND_WATER: begin
                if (in_i.tank_has_water) begin
                  count_q <= '0;
                  pulse_q <= 1'b1;
                end
              end
              KIND_FORCE: forced_q <= in_i.force_value;
              default: ;
            endcase
          end
        end
        S_DROP: begin
          cnt_q <= cnt_q + 1'b1;
          if (div_last) begin
            target_q <= FullDrive - quo_n[LevelW-1:0];
          end
        end
        S_PCT:  percent_q <= pct_n;
        S_RAMP: if (tick_q) ramp_q <= ramp_n;
        S_OUT: ;
        default: ;
      endcase
    end
  end

  // Divider datapath: loaded with the drop division when the item is accepted.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_acc) begin
      quo_q <= drop_dvd;
      rem_q <= '0;
      dsr_q <= light_high_q - light_low_q;
    end else if (state_q == S_DROP) begin
      quo_q <= quo_n;
      rem_q <= rem_n;
    end
  end

  // Result register.
  logic [LevelW-1:0] drive, green;

  always_comb begin
    drive = mode_q[ModeInvert] ? FullDrive - ramp_q : ramp_q;
    if (mode_q[ModeGreenOn]) begin
      green = drive;
    end else begin
      green = mode_q[ModeInvert] ? FullDrive : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_free) begin
      red_q         <= drive;
      green_q       <= green;
      blue_q        <= drive;
      out_pct_q     <= percent_q;
      out_pulse_q   <= pulse_q;
      out_count_q   <= count_q;
      out_allowed_q <= allowed_q;
    end
  end

  assign out_o.valid               = out_valid_q;
  assign out_o.red_drive           = red_q;
  assign out_o.green_drive         = green_q;
  assign out_o.blue_drive          = blue_q;
  assign out_o.light_percent       = out_pct_q;
  assign out_o.pump_pulse          = out_pulse_q;
  assign out_o.minutes_since_water = out_count_q;
  assign out_o.light_allowed       = out_allowed_q;

  // An accepted item always takes the sequencer out of the idle state in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != S_IDLE))
    else $error("sequencer stayed idle after an accepted item");

  // The percent value never exceeds full brightness.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    percent_q <= PercentMax)
    else $error("percent value above maximum");

  // The drive ramps by no more than one step per cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((ramp_q >= $past(ramp_q)) ? (ramp_q - $past(ramp_q)) : ($past(ramp_q) - ramp_q))
      <= RampStep)
    else $error("ramp moved by more than one step");

  // The result register is loaded only when it is free.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_valid_q && !out_o.ready) |=> (state_q == S_OUT))
    else $error("result dropped while output stalled");

endmodule
